[src/fast_packet_reassembler_defines.svh]
`ifndef FAST_PACKET_REASSEMBLER_DEFINES_SVH
`define FAST_PACKET_REASSEMBLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/fpr_pkg.sv]
`default_nettype none
package fpr_pkg;

  localparam int SlotsDefault    = 8;
  localparam int MaxBytesDefault = 256;
  localparam int KeyW            = 37;
  localparam int PgnW            = 18;

  localparam logic [4:0] SeqMask = 5'h1F;
  localparam logic [2:0] CtrMask = 3'h7;

  localparam logic [PgnW-1:0] ClaimPgnReset = 18'd60928;
  localparam logic [PgnW-1:0] ProdPgnReset  = 18'd126996;

  localparam logic [7:0] CfgClaim = 8'd0;
  localparam logic [7:0] CfgProd  = 8'd1;

  localparam logic [2:0] StProcessed = 3'd0;
  localparam logic [2:0] StComplete  = 3'd1;
  localparam logic [2:0] StDevInfo   = 3'd2;
  localparam logic [2:0] StUnknown   = 3'd3;
  localparam logic [2:0] StBadSeq    = 3'd4;
  localparam logic [2:0] StFull      = 3'd5;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_ALLOC,
    CMD_UPDATE,
    CMD_FREE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t         op;
    logic [KeyW-1:0] key;
    logic [7:0]      expected;
    logic [4:0]      frame_count;
    logic [7:0]      received;
  } cell_cmd_t;

  typedef struct packed {
    logic       hit;
    logic       free;
    logic [7:0] expected;
    logic [4:0] frame_count;
    logic [7:0] received;
  } cell_link_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[src/fast_packet_reassembler.sv]
// channel  | handshake               | payload
// in_      | in_valid / in_stall     | one received can frame
// out_     | out_valid / out_stall   | one 8-byte message chunk per beat
// cfg_     | cfg_valid / cfg_ready   | register index and data
// a frame is captured and looked up; its fast-packet bytes are written to the buffer
// ram, then a completed message is read back chunk by chunk, or one result is shown
// slot lookup is a chain of slot cells, message bytes live in one buffer ram
// reset is synchronous, active low, and frees every slot at once
// out_stall holds the current chunk; no frame is taken until a run is done
`default_nettype none
module fast_packet_reassembler
  import fpr_pkg::*;
#(
  parameter int SLOTS     = SlotsDefault,
  parameter int MAX_BYTES = MaxBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [17:0] in_pgn,
  input  wire logic [7:0]  in_source_addr,
  input  wire logic [7:0]  in_dest_addr,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic [63:0] in_frame_data,
  input  wire logic        in_pgn_known,
  input  wire logic        in_is_fast,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [2:0]  out_status,
  output      logic [17:0] out_pgn,
  output      logic [7:0]  out_source,
  output      logic [7:0]  out_dest,
  output      logic [7:0]  out_total_bytes,
  output      logic [63:0] out_chunk_data,
  output      logic [4:0]  out_chunk_index,
  output      logic        out_last,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [17:0] cfg_data
);

`include "fast_packet_reassembler_defines.svh"

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WPS = (MAX_BYTES + 7) / 8;
  localparam int DEPTH = SLOTS * WPS;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_WR0, S_WR1, S_RD, S_RDW, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [17:0] claim_r, prod_r;
  logic [17:0] pgn_r;
  logic [7:0]  src_r, dst_r;
  logic [3:0]  bc_r;
  logic [63:0] frame_r;
  logic        known_r, fast_r;

  logic [2:0]  st_r;
  logic [17:0] opgn_r;
  logic [7:0]  osrc_r, odst_r, len_r;
  logic [63:0] odata_r;
  logic [4:0]  k_r;
  logic        olast_r;
  logic        emit_buf_r;
  logic [IW-1:0] w_slot_r;
  logic [7:0]  w_off_r;
  logic [55:0] w_data_r;
  logic [3:0]  w_cnt_r;

  logic [KeyW-1:0] key;
  cell_cmd_t       cmd;
  logic [IW-1:0]   cmd_slot;
  cell_link_t      link [SLOTS+1];
  logic [IW-1:0]   hidx [SLOTS+1];
  logic [IW-1:0]   fidx [SLOTS+1];
  logic [SLOTS-1:0] hit_vec;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wbe;
  logic [63:0]   mem_wdata, mem_rdata;
  logic [127:0]  shifted;
  logic [15:0]   be16;
  logic [4:0]    w_word;

  logic [2:0]  dev_st;
  logic [3:0]  n_hit;
  logic [8:0]  sum_hit;
  logic        done_hit;
  logic [3:0]  n_use;
  logic [8:0]  exp9;
  logic [7:0]  exp_new;
  logic [3:0]  avail;
  logic [7:0]  last_k;
  logic [63:0] rd_mask;

  function automatic logic [AW-1:0] waddr_of(input logic [IW-1:0] slot,
                                             input logic [4:0] word);
    return AW'(AW'(slot) * AW'(WPS) + AW'(word));
  endfunction

  assign key = {dst_r, src_r, pgn_r, frame_r[7:5] & CtrMask};

  assign link[0] = '0;
  assign hidx[0] = '0;
  assign fidx[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    fpr_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk, .rst_n, .key, .cmd, .cmd_slot,
      .link_in(link[g]), .hit_idx_in(hidx[g]), .free_idx_in(fidx[g]),
      .link_out(link[g+1]), .hit_idx_out(hidx[g+1]), .free_idx_out(fidx[g+1]),
      .sel_hit(hit_vec[g])
    );
  end

  fpr_buf #(.DEPTH(DEPTH), .AW(AW)) u_buf (
    .clk, .we(mem_we), .waddr(mem_waddr), .wbe(mem_wbe), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // lookup-cycle decisions
  always_comb begin
    dev_st   = ((pgn_r == claim_r) || (pgn_r == prod_r)) ? StDevInfo : StComplete;
    n_hit    = (bc_r != 4'd0) ? bc_r - 4'd1 : 4'd0;
    sum_hit  = 9'(link[SLOTS].received) + 9'(n_hit);
    done_hit = sum_hit >= 9'(link[SLOTS].expected);
    n_use    = done_hit ? 4'(link[SLOTS].expected - link[SLOTS].received) : n_hit;
    exp9     = {1'b0, frame_r[15:8]};
    exp_new  = (exp9 > 9'(MAX_BYTES)) ? 8'(MAX_BYTES) : frame_r[15:8];
    avail    = (bc_r > 4'd2) ? bc_r - 4'd2 : 4'd0;
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = CMD_NOP;
    cmd.key      = key;
    cmd.expected = exp_new;
    cmd_slot     = hidx[SLOTS];
    if (state_r == S_LOOK) begin
      if (link[SLOTS].hit) begin
        if ((frame_r[4:0] & SeqMask) != link[SLOTS].frame_count) begin
          cmd.op = CMD_FREE;
        end else begin
          cmd.op          = done_hit ? CMD_FREE : CMD_UPDATE;
          cmd.frame_count = link[SLOTS].frame_count + 5'd1;
          cmd.received    = link[SLOTS].received + 8'(n_use);
        end
      end else if (known_r && fast_r && (frame_r[4:0] & SeqMask) == 5'd0
                   && {1'b0, exp_new} > 9'(avail) && link[SLOTS].free) begin
        cmd.op          = CMD_ALLOC;
        cmd.frame_count = 5'd1;
        cmd.received    = 8'(avail);
        cmd_slot        = fidx[SLOTS];
      end
    end
  end

  // buffer write path, read address and read mask
  always_comb begin
    shifted   = {72'd0, w_data_r} << {w_off_r[2:0], 3'b000};
    be16      = 16'((8'd1 << w_cnt_r) - 8'd1) << w_off_r[2:0];
    w_word    = w_off_r[7:3];
    mem_we    = (state_r == S_WR0) || (state_r == S_WR1);
    mem_wbe   = (state_r == S_WR1) ? be16[15:8] : be16[7:0];
    mem_wdata = (state_r == S_WR1) ? shifted[127:64] : shifted[63:0];
    mem_waddr = waddr_of(w_slot_r, (state_r == S_WR1) ? w_word + 5'd1 : w_word);
    mem_raddr = waddr_of(w_slot_r, k_r);
    last_k    = (len_r - 8'd1) >> 3;
    for (int i = 0; i < 8; i++) begin
      rd_mask[8*i +: 8] = ({k_r, 3'(i)} < len_r) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_LOOK;
      S_LOOK: begin
        if (link[SLOTS].hit) begin
          if ((frame_r[4:0] & SeqMask) != link[SLOTS].frame_count) state_nxt = S_OUT;
          else state_nxt = S_WR0;
        end else if (known_r && fast_r && (frame_r[4:0] & SeqMask) == 5'd0
                     && {1'b0, exp_new} > 9'(avail) && link[SLOTS].free) begin
          state_nxt = S_WR0;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_WR0: begin
        if (be16[15:8] != 8'd0) state_nxt = S_WR1;
        else state_nxt = emit_buf_r ? S_RD : S_OUT;
      end
      S_WR1: state_nxt = emit_buf_r ? S_RD : S_OUT;
      S_RD:  state_nxt = S_RDW;
      S_RDW: state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = olast_r ? S_IDLE : S_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      claim_r <= ClaimPgnReset;
      prod_r  <= ProdPgnReset;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_index == CfgClaim) claim_r <= cfg_data;
      if (cfg_valid && cfg_index == CfgProd)  prod_r  <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        pgn_r   <= in_pgn;
        src_r   <= in_source_addr;
        dst_r   <= in_dest_addr;
        bc_r    <= (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
        frame_r <= in_frame_data &
                   byte_mask((in_byte_count > 4'd8) ? 4'd8 : in_byte_count);
        known_r <= in_pgn_known;
        fast_r  <= in_is_fast;
      end
      S_LOOK: begin
        // default: echo the frame
        st_r       <= StProcessed;
        opgn_r     <= pgn_r;
        osrc_r     <= src_r;
        odst_r     <= dst_r;
        len_r      <= 8'(bc_r);
        odata_r    <= frame_r;
        k_r        <= 5'd0;
        olast_r    <= 1'b1;
        emit_buf_r <= 1'b0;
        if (link[SLOTS].hit) begin
          w_slot_r <= hidx[SLOTS];
          w_off_r  <= link[SLOTS].received;
          w_data_r <= frame_r[63:8];
          w_cnt_r  <= n_use;
          if ((frame_r[4:0] & SeqMask) != link[SLOTS].frame_count) begin
            st_r <= StBadSeq;
          end else if (done_hit) begin
            st_r       <= dev_st;
            len_r      <= link[SLOTS].expected;
            olast_r    <= 1'b0;
            emit_buf_r <= 1'b1;
          end else begin
            opgn_r  <= '0;
            osrc_r  <= '0;
            odst_r  <= '0;
            len_r   <= '0;
            odata_r <= '0;
          end
        end else if (!known_r) begin
          st_r <= StUnknown;
        end else if (!fast_r) begin
          st_r <= dev_st;
        end else if ((frame_r[4:0] & SeqMask) != 5'd0) begin
          st_r <= StBadSeq;
        end else if ({1'b0, exp_new} <= 9'(avail)) begin
          st_r    <= dev_st;
          len_r   <= exp_new;
          odata_r <= {16'd0, frame_r[63:16]} & byte_mask(exp_new[3:0]);
        end else if (!link[SLOTS].free) begin
          st_r <= StFull;
        end else begin
          w_slot_r <= fidx[SLOTS];
          w_off_r  <= '0;
          w_data_r <= {8'd0, frame_r[63:16]};
          w_cnt_r  <= avail;
          opgn_r   <= '0;
          osrc_r   <= '0;
          odst_r   <= '0;
          len_r    <= '0;
          odata_r  <= '0;
        end
      end
      S_RDW: begin
        odata_r <= mem_rdata & rd_mask;
        olast_r <= (8'(k_r) == last_k);
      end
      S_OUT: if (!out_stall && !olast_r) k_r <= k_r + 5'd1;
      default: ;
    endcase
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign cfg_ready       = 1'b1;
  assign out_status      = st_r;
  assign out_pgn         = opgn_r;
  assign out_source      = osrc_r;
  assign out_dest        = odst_r;
  assign out_total_bytes = len_r;
  assign out_chunk_data  = odata_r;
  assign out_chunk_index = k_r;
  assign out_last        = olast_r;

  `FPR_ASSERT_NOW(a_no_take_while_out, out_valid, in_stall, "frame taken during output")
  `FPR_ASSERT_NOW(a_one_hit, 1'b1, $onehot0(hit_vec), "more than one slot hit")
  `FPR_ASSERT_NOW(a_processed_single, out_valid && out_status == StProcessed, out_last,
                  "processed result not single")
  `FPR_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !out_last, state_r == S_RD,
                   "chunk run broken")

endmodule
`default_nettype wire

[src/fpr_cell.sv]
`default_nettype none
module fpr_cell
  import fpr_pkg::*;
#(
  parameter int IW  = 3,
  parameter int IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [KeyW-1:0] key,
  input  wire cell_cmd_t       cmd,
  input  wire logic [IW-1:0]   cmd_slot,
  input  wire cell_link_t      link_in,
  input  wire logic [IW-1:0]   hit_idx_in,
  input  wire logic [IW-1:0]   free_idx_in,
  output      cell_link_t      link_out,
  output      logic [IW-1:0]   hit_idx_out,
  output      logic [IW-1:0]   free_idx_out,
  output      logic            sel_hit
);

  logic            valid_r;
  logic [KeyW-1:0] key_r;
  logic [7:0]      exp_r;
  logic [4:0]      cnt_r;
  logic [7:0]      rcv_r;
  logic            match;
  logic            sel_free;
  logic            mine;

  assign match    = valid_r && (key_r == key);
  assign sel_hit  = match && !link_in.hit;
  assign sel_free = !valid_r && !link_in.free;
  assign mine     = (cmd_slot == IW'(IDX));

  always_comb begin
    link_out      = link_in;
    link_out.hit  = link_in.hit | match;
    link_out.free = link_in.free | !valid_r;
    hit_idx_out   = hit_idx_in;
    free_idx_out  = free_idx_in;
    if (sel_hit) begin
      link_out.expected    = exp_r;
      link_out.frame_count = cnt_r;
      link_out.received    = rcv_r;
      hit_idx_out          = IW'(IDX);
    end
    if (sel_free) free_idx_out = IW'(IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (mine) begin
      case (cmd.op)
        CMD_ALLOC: begin
          valid_r <= 1'b1;
          key_r   <= cmd.key;
          exp_r   <= cmd.expected;
          cnt_r   <= cmd.frame_count;
          rcv_r   <= cmd.received;
        end
        CMD_UPDATE: begin
          cnt_r   <= cmd.frame_count;
          rcv_r   <= cmd.received;
        end
        CMD_FREE: valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/fpr_buf.sv]
`default_nettype none
module fpr_buf
  import fpr_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wbe,
  input  wire logic [63:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output      logic [63:0]   rdata
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < 8; i++) begin
        if (wbe[i]) mem[waddr][8*i +: 8] <= wdata[8*i +: 8];
      end
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[verif/tb_fast_packet_reassembler.sv]
`default_nettype none
module tb_fast_packet_reassembler;
  import fpr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [17:0] pgn;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [3:0]  bc;
    logic [63:0] data;
    logic        known;
    logic        fast;
  } frame_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [17:0] pgn;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  total;
    logic [63:0] data;
    logic [4:0]  index;
    logic        last;
  } chunk_t;

  class reassembly_scoreboard;
    logic [17:0] claim_pgn = ClaimPgnReset;
    logic [17:0] prod_pgn = ProdPgnReset;
    bit          open[8];
    logic [36:0] key[8];
    int          expected_len[8];
    logic [4:0]  next_ctr[8];
    int          received[8];
    logic [7:0]  buffer[8][256];
    chunk_t      chunk_q[$];
    int          errors = 0;
    int          frames = 0;
    int          chunks = 0;
    int          completed = 0;

    function void set_reg(logic [7:0] idx, logic [17:0] val);
      if (idx == CfgClaim) claim_pgn = val;
      else if (idx == CfgProd) prod_pgn = val;
    endfunction

    function int open_count();
      int n;
      n = 0;
      foreach (open[s]) if (open[s]) n++;
      return n;
    endfunction

    function logic [2:0] done_status(logic [17:0] pgn);
      return (pgn == claim_pgn || pgn == prod_pgn) ? StDevInfo : StComplete;
    endfunction

    function void push_message(logic [2:0] st, logic [17:0] pgn, logic [7:0] src,
                               logic [7:0] dst, logic [7:0] msg[256], int len);
      int     n;
      chunk_t c;
      n = (len + 7) / 8;
      if (n == 0) n = 1;
      if (st == StComplete || st == StDevInfo) completed++;
      for (int k = 0; k < n; k++) begin
        c = '0;
        c.status = st;
        c.pgn = pgn;
        c.src = src;
        c.dst = dst;
        c.total = len[7:0];
        for (int i = 0; i < 8; i++)
          if (k * 8 + i < len) c.data[8*i +: 8] = msg[k * 8 + i];
        c.index = k[4:0];
        c.last = (k + 1 == n);
        chunk_q.push_back(c);
      end
    endfunction

    function void note_frame(frame_t f);
      logic [7:0]  fr[256];
      logic [7:0]  msg[256];
      logic [36:0] k;
      int          bc, hit, n, rcv, len, avail, s;
      logic [4:0]  seq;
      frames++;
      foreach (msg[i]) msg[i] = '0;
      foreach (fr[i]) fr[i] = '0;
      bc = f.bc > 8 ? 8 : f.bc;
      for (int i = 0; i < 8; i++) fr[i] = i < bc ? f.data[8*i +: 8] : 8'h00;
      seq = fr[0][4:0];
      k = {f.dst, f.src, f.pgn, fr[0][7:5]};
      hit = -1;
      for (int i = 0; i < 8; i++)
        if (hit < 0 && open[i] && key[i] == k) hit = i;
      if (hit >= 0) begin
        n = bc > 0 ? bc - 1 : 0;
        rcv = received[hit];
        len = expected_len[hit];
        if (seq != next_ctr[hit]) begin
          open[hit] = 0;
          push_message(StBadSeq, f.pgn, f.src, f.dst, fr, bc);
          return;
        end
        if (rcv + n >= len) n = len - rcv;
        for (int i = 0; i < n; i++) buffer[hit][(rcv + i) % 256] = fr[1 + i];
        received[hit] = rcv + n;
        next_ctr[hit] = next_ctr[hit] + 5'd1;
        if (received[hit] < len) begin
          push_message(StProcessed, '0, '0, '0, msg, 0);
          return;
        end
        open[hit] = 0;
        for (int i = 0; i < len; i++) msg[i] = buffer[hit][i];
        push_message(done_status(f.pgn), f.pgn, f.src, f.dst, msg, len);
        return;
      end
      if (!f.known) begin
        push_message(StUnknown, f.pgn, f.src, f.dst, fr, bc);
        return;
      end
      if (!f.fast) begin
        push_message(done_status(f.pgn), f.pgn, f.src, f.dst, fr, bc);
        return;
      end
      if (seq != 0) begin
        push_message(StBadSeq, f.pgn, f.src, f.dst, fr, bc);
        return;
      end
      avail = bc > 2 ? bc - 2 : 0;
      len = fr[1];
      if (len <= avail) begin
        for (int i = 0; i < len; i++) msg[i] = fr[2 + i];
        push_message(done_status(f.pgn), f.pgn, f.src, f.dst, msg, len);
        return;
      end
      s = -1;
      for (int i = 0; i < 8; i++) if (s < 0 && !open[i]) s = i;
      if (s < 0) begin
        push_message(StFull, f.pgn, f.src, f.dst, fr, bc);
        return;
      end
      open[s] = 1;
      key[s] = k;
      expected_len[s] = len;
      next_ctr[s] = 5'd1;
      received[s] = avail;
      for (int i = 0; i < avail; i++) buffer[s][i] = fr[2 + i];
      push_message(StProcessed, '0, '0, '0, msg, 0);
    endfunction

    function void check_chunk(chunk_t got);
      chunk_t e;
      chunks++;
      if (chunk_q.size() == 0) begin
        $error("unexpected beat on result channel: status %0d", got.status);
        errors++;
        return;
      end
      e = chunk_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); errors++;
      end
      if (got.pgn !== e.pgn) begin
        $error("out_pgn: expected %0d, got %0d", e.pgn, got.pgn); errors++;
      end
      if (got.src !== e.src) begin
        $error("out_source: expected %0d, got %0d", e.src, got.src); errors++;
      end
      if (got.dst !== e.dst) begin
        $error("out_dest: expected %0d, got %0d", e.dst, got.dst); errors++;
      end
      if (got.total !== e.total) begin
        $error("total_bytes: expected %0d, got %0d", e.total, got.total); errors++;
      end
      if (got.data !== e.data) begin
        $error("chunk_data: expected %h, got %h", e.data, got.data); errors++;
      end
      if (got.index !== e.index) begin
        $error("chunk_index: expected %0d, got %0d", e.index, got.index); errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [17:0] in_pgn = '0;
  logic [7:0]  in_source_addr = '0;
  logic [7:0]  in_dest_addr = '0;
  logic [3:0]  in_byte_count = '0;
  logic [63:0] in_frame_data = '0;
  logic        in_pgn_known = 0;
  logic        in_is_fast = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  out_status;
  logic [17:0] out_pgn;
  logic [7:0]  out_source;
  logic [7:0]  out_dest;
  logic [7:0]  out_total_bytes;
  logic [63:0] out_chunk_data;
  logic [4:0]  out_chunk_index;
  logic        out_last;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  fast_packet_reassembler dut (.*);

  reassembly_scoreboard sb = new();
  bit     no_idle = 0;
  int     stall_left = 0;
  frame_t stream_q[4][$];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_chunk({out_status, out_pgn, out_source, out_dest, out_total_bytes,
                      out_chunk_data, out_chunk_index, out_last});
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else begin
      stall_left <= idle_len();
      out_stall <= 0;
    end
  end

  task automatic send_frame(frame_t f);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_pgn <= f.pgn;
    in_source_addr <= f.src;
    in_dest_addr <= f.dst;
    in_byte_count <= f.bc;
    in_frame_data <= f.data;
    in_pgn_known <= f.known;
    in_is_fast <= f.fast;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_frame(f);
  endtask

  task automatic finish_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    finish_input();
    while (sb.chunk_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [17:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic frame_t make_frame(logic [17:0] pgn, logic [7:0] b0, logic [7:0] b1,
                                        int bc, bit known, bit fast);
    frame_t f;
    f.pgn = pgn;
    f.src = 8'($urandom);
    f.dst = 8'($urandom);
    f.bc = 4'(bc);
    f.data = {$urandom, $urandom};
    f.data[7:0] = b0;
    f.data[15:8] = b1;
    f.known = known;
    f.fast = fast;
    return f;
  endfunction

  // close every open slot with a counter mismatch
  task automatic flush_slots();
    frame_t f;
    for (int s = 0; s < 8; s++) begin
      if (sb.open[s]) begin
        f = make_frame(sb.key[s][20:3], {sb.key[s][2:0], sb.next_ctr[s] + 5'd1}, 8'h00,
                       $urandom_range(1, 8), 1'($urandom), 1'($urandom));
        f.src = sb.key[s][28:21];
        f.dst = sb.key[s][36:29];
        send_frame(f);
      end
    end
    foreach (stream_q[i]) stream_q[i].delete();
  endtask

  task automatic build_packet(int slot);
    frame_t     f;
    logic [2:0] ctr;
    logic [4:0] fc;
    int         len, left, bc;
    logic [17:0] pgn;
    case ($urandom_range(0, 3))
      0: pgn = sb.claim_pgn;
      1: pgn = sb.prod_pgn;
      default: pgn = 18'($urandom);
    endcase
    ctr = 3'($urandom);
    len = $urandom_range(0, 99) < 88 ? $urandom_range(0, 40) : $urandom_range(41, 255);
    bc = $urandom_range(0, 9) < 8 ? 8 : $urandom_range(0, 15);
    f = make_frame(pgn, {ctr, 5'd0}, len[7:0], bc, 1, 1);
    stream_q[slot].push_back(f);
    left = len - (bc > 8 ? 6 : (bc > 2 ? bc - 2 : 0));
    fc = 5'd1;
    while (left > 0) begin
      bc = $urandom_range(0, 9) < 8 ? 8 : $urandom_range(0, 8);
      f.data = {$urandom, $urandom};
      f.data[7:0] = {ctr, fc};
      f.bc = 4'(bc);
      f.known = 1'($urandom);
      f.fast = 1'($urandom);
      stream_q[slot].push_back(f);
      left -= bc > 0 ? bc - 1 : 0;
      fc++;
    end
  endtask

  task automatic random_phase(int count);
    frame_t f;
    int     s, r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 3);
      if (sb.open_count() >= 7) flush_slots();
      if (r < 80) begin
        if (stream_q[s].size() == 0) build_packet(s);
        f = stream_q[s].pop_front();
        if ($urandom_range(0, 29) == 0)
          f.data[4:0] = 5'(f.data[4:0] + $urandom_range(1, 31));
      end else begin
        f = make_frame(18'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 15),
                       1'($urandom), 1'($urandom));
        if ($urandom_range(0, 1)) f.data[4:0] = 5'($urandom_range(1, 31));
      end
      send_frame(f);
    end
  endtask

  task automatic directed();
    frame_t f;
    send_frame(make_frame(18'h3FFFF, 8'hFF, 8'hFF, 8, 0, 1));
    f = make_frame(18'h00000, 8'h00, 8'h00, 0, 1, 0);
    f.src = 8'h00;
    f.dst = 8'hFF;
    send_frame(f);
    f = make_frame(sb.claim_pgn, 8'hFF, 8'hFF, 15, 1, 0);
    f.data = '1;
    f.src = 8'hFF;
    f.dst = 8'h00;
    send_frame(f);
    send_frame(make_frame(sb.prod_pgn, 8'h12, 8'h34, 5, 1, 0));
    send_frame(make_frame(18'h1F00A, 8'h05, 8'h02, 8, 1, 1));
    send_frame(make_frame(18'h1F00B, 8'h00, 8'h00, 1, 1, 1));
    send_frame(make_frame(18'h1F00C, 8'h20, 8'h00, 0, 1, 1));
    send_frame(make_frame(sb.prod_pgn, 8'h40, 8'h06, 8, 1, 1));
    send_frame(make_frame(18'h1F00D, 8'h60, 8'h00, 2, 1, 1));
    for (int i = 0; i < 9; i++)
      send_frame(make_frame(18'(18'h1F100 + i), {3'(i), 5'd0}, 8'd200, 2, 1, 1));
    // later frame with no bytes still advances the counter
    f = make_frame(18'h1F100, 8'h00, 8'h00, 1, 1, 1);
    f.src = sb.key[0][28:21];
    f.dst = sb.key[0][36:29];
    f.data[7:0] = 8'h01;
    send_frame(f);
    f.data[7:0] = 8'h02;
    f.bc = 8;
    send_frame(f);
    flush_slots();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed();
    drain();
    write_reg(CfgClaim, 18'h00000);
    write_reg(CfgProd, 18'h3FFFF);
    write_reg(8'd2, 18'h12345);
    write_reg(8'hFF, 18'h3FFFF);
    random_phase(40);
    flush_slots();
    drain();
    write_reg(CfgClaim, 18'h3FFFF);
    write_reg(CfgProd, 18'h00000);
    no_idle = 1;
    random_phase(40);
    flush_slots();
    drain();
    no_idle = 0;
    write_reg(CfgClaim, 18'($urandom));
    write_reg(CfgProd, ClaimPgnReset);
    random_phase(40);
    flush_slots();
    drain();
    $display("%0d frames sent, %0d beats checked, %0d messages completed",
             sb.frames, sb.chunks, sb.completed);
    $display("covered pass-through, echoes, table full, counter errors and register changes");
    if (sb.errors == 0 && sb.chunk_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

[fast_packet_reassembler.f]
+incdir+src
src/fpr_pkg.sv
src/fpr_cell.sv
src/fpr_buf.sv
src/fast_packet_reassembler.sv
verif/tb_fast_packet_reassembler.sv
